/* rtl/etl_pkg.sv */
// shared types, character constants and helper functions of the expression token lexer
package etl_pkg;

  localparam int CHAR_W       = 8;
  localparam int POS_W        = 12;
  localparam int SUM_W        = POS_W + 2;
  localparam int POS_MAX      = (1 << POS_W) - 1;
  localparam int MAX_TEXT_DEF = 4096;

  // front-to-back queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_0      = 8'h30;
  localparam char_t CH_9      = 8'h39;
  localparam char_t CH_EQUAL  = 8'h3D;
  localparam char_t CH_A_UP   = 8'h41;
  localparam char_t CH_E_UP   = 8'h45;
  localparam char_t CH_Z_UP   = 8'h5A;
  localparam char_t CH_A_LO   = 8'h61;
  localparam char_t CH_E_LO   = 8'h65;
  localparam char_t CH_Z_LO   = 8'h7A;

  typedef enum logic [2:0] {
    K_STOP,
    K_LP,
    K_RP,
    K_EQ,
    K_NUM,
    K_SYM,
    K_OP
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SYM,
    M_INT,
    M_FRAC,
    M_MINUS,
    M_DOT,
    M_EXP,
    M_ESIGN,
    M_EDIG
  } mode_t;

  typedef struct packed {
    logic nul;
    logic space;
    logic digit;
    logic alpha;
    logic lparen;
    logic rparen;
    logic equal;
    logic minus;
    logic plus;
    logic dot;
    logic expo;
  } cls_t;

  typedef struct packed {
    char_t code;
    cls_t  cls;
  } chr_t;

  typedef struct packed {
    chr_t ch;
    pos_t pos;
  } item_t;

  typedef struct packed {
    kind_t kind;
    pos_t  start;
    pos_t  len;
    char_t first;
  } token_t;

  function automatic cls_t char_class(input char_t c);
    cls_t k;
    k.nul    = (c == CH_NUL);
    k.space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    k.digit  = (c >= CH_0 && c <= CH_9);
    k.alpha  = (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP);
    k.lparen = (c == CH_LPAREN);
    k.rparen = (c == CH_RPAREN);
    k.equal  = (c == CH_EQUAL);
    k.minus  = (c == CH_MINUS);
    k.plus   = (c == CH_PLUS);
    k.dot    = (c == CH_DOT);
    k.expo   = (c == CH_E_LO) || (c == CH_E_UP);
    return k;
  endfunction

  function automatic pos_t sat_pos(input logic [SUM_W-1:0] s, input pos_t top);
    return (s > SUM_W'(top)) ? top : s[POS_W-1:0];
  endfunction

endpackage

/* rtl/etl_front.sv */
// front end: byte intake, position counter and character classification
module etl_front #(
  parameter int MAX_TEXT = etl_pkg::MAX_TEXT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  etl_pkg::char_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output etl_pkg::item_t out_item
);

  localparam etl_pkg::pos_t POS_TOP = (MAX_TEXT - 1 > etl_pkg::POS_MAX) ?
                                      etl_pkg::pos_t'(etl_pkg::POS_MAX) :
                                      etl_pkg::pos_t'(MAX_TEXT - 1);

  etl_pkg::pos_t pos;
  etl_pkg::pos_t pos_next;
  etl_pkg::cls_t cls;
  logic          accept;

  assign cls       = etl_pkg::char_class(in_data);
  assign accept    = in_valid && out_ready;
  assign in_ready  = out_ready;
  assign out_valid = in_valid;

  assign out_item.ch.code = in_data;
  assign out_item.ch.cls  = cls;
  assign out_item.pos     = pos;

  // end of text restarts the offsets at zero
  assign pos_next = cls.nul ? '0 :
                    etl_pkg::sat_pos(etl_pkg::SUM_W'(pos) + etl_pkg::SUM_W'(1), POS_TOP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= pos_next;
    end
  end

endmodule

/* rtl/etl_fifo.sv */
// short queue of classified bytes between front end and lexer engine
module etl_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  etl_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_pop,
  output etl_pkg::item_t rd_item
);

  etl_pkg::item_t                 slots [etl_pkg::Q_DEPTH];
  logic [etl_pkg::Q_AW-1:0]       wr_ptr;
  logic [etl_pkg::Q_AW-1:0]       rd_ptr;
  logic [etl_pkg::Q_CW-1:0]       count;
  logic                           push;
  logic                           pop;

  assign wr_ready = (count != etl_pkg::Q_CW'(etl_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + etl_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + etl_pkg::Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + etl_pkg::Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - etl_pkg::Q_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

/* rtl/etl_back.sv */
// lexer engine: token state machine, byte replay and result staging
module etl_back #(
  parameter int MAX_TEXT = etl_pkg::MAX_TEXT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  etl_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            m_valid,
  input  logic            m_ready,
  output etl_pkg::token_t m_token,
  output logic            m_last
);

  localparam etl_pkg::pos_t POS_TOP = (MAX_TEXT - 1 > etl_pkg::POS_MAX) ?
                                      etl_pkg::pos_t'(etl_pkg::POS_MAX) :
                                      etl_pkg::pos_t'(MAX_TEXT - 1);

  // lexer state
  etl_pkg::mode_t mode, mode_next;
  etl_pkg::kind_t lc, lc_next;
  etl_pkg::pos_t  ts, ts_next;
  etl_pkg::pos_t  tl, tl_next;
  etl_pkg::char_t tf, tf_next;
  logic [1:0]     pc, pc_next;
  etl_pkg::chr_t  pend [2];
  etl_pkg::chr_t  pend_next [2];

  // bytes handed back for another pass
  etl_pkg::item_t rb [2];
  logic [1:0]     r_cnt;
  logic [1:0]     drop_n;
  etl_pkg::item_t d0, d1;

  // byte under work
  etl_pkg::item_t  f;
  logic            f_v;
  logic            sign_ok;
  logic            take;
  logic            em_v;
  etl_pkg::token_t em;
  logic            go;

  // result staging and output register
  etl_pkg::token_t h_tok;
  logic            h_v;
  logic            h_fin;
  logic            h_move;
  etl_pkg::token_t o_tok;
  logic            o_v;
  logic            o_last;
  logic            o_free;

  logic [etl_pkg::SUM_W-1:0] sum_tl1;
  logic [etl_pkg::SUM_W-1:0] sum_tlpc;
  logic [etl_pkg::SUM_W-1:0] sum_end0;
  logic [etl_pkg::SUM_W-1:0] sum_end1;

  assign f   = (r_cnt != 2'd0) ? rb[0] : q_item;
  assign f_v = (r_cnt != 2'd0) || q_valid;

  assign sign_ok = (lc == etl_pkg::K_LP) || (lc == etl_pkg::K_OP) || (lc == etl_pkg::K_EQ);

  assign sum_tl1  = etl_pkg::SUM_W'(tl) + etl_pkg::SUM_W'(1);
  assign sum_tlpc = etl_pkg::SUM_W'(tl) + etl_pkg::SUM_W'(pc) + etl_pkg::SUM_W'(1);
  assign sum_end0 = etl_pkg::SUM_W'(ts) + etl_pkg::SUM_W'(tl);
  assign sum_end1 = sum_end0 + etl_pkg::SUM_W'(1);

  // next state
  always_comb begin
    mode_next = mode;
    case (mode)
      etl_pkg::M_SYM: begin
        if (!(f.ch.cls.digit || f.ch.cls.alpha)) begin
          mode_next = etl_pkg::M_IDLE;
        end
      end
      etl_pkg::M_INT, etl_pkg::M_FRAC, etl_pkg::M_EDIG: begin
        if (f.ch.cls.digit) begin
          mode_next = mode;
        end else if (mode == etl_pkg::M_INT && f.ch.cls.dot) begin
          mode_next = etl_pkg::M_FRAC;
        end else if (mode != etl_pkg::M_EDIG && f.ch.cls.expo) begin
          mode_next = etl_pkg::M_EXP;
        end else begin
          mode_next = etl_pkg::M_IDLE;
        end
      end
      etl_pkg::M_EXP, etl_pkg::M_ESIGN: begin
        if (f.ch.cls.digit) begin
          mode_next = etl_pkg::M_EDIG;
        end else if (mode == etl_pkg::M_EXP && (f.ch.cls.plus || f.ch.cls.minus)) begin
          mode_next = etl_pkg::M_ESIGN;
        end else begin
          mode_next = etl_pkg::M_IDLE;
        end
      end
      etl_pkg::M_MINUS, etl_pkg::M_DOT: begin
        if (f.ch.cls.digit) begin
          mode_next = (mode == etl_pkg::M_MINUS) ? etl_pkg::M_INT : etl_pkg::M_FRAC;
        end else if (mode == etl_pkg::M_MINUS && f.ch.cls.dot) begin
          mode_next = etl_pkg::M_DOT;
        end else begin
          mode_next = etl_pkg::M_IDLE;
        end
      end
      default: begin
        if (f.ch.cls.digit) begin
          mode_next = etl_pkg::M_INT;
        end else if (f.ch.cls.dot) begin
          mode_next = etl_pkg::M_DOT;
        end else if (f.ch.cls.minus && sign_ok) begin
          mode_next = etl_pkg::M_MINUS;
        end else if (f.ch.cls.alpha) begin
          mode_next = etl_pkg::M_SYM;
        end else begin
          mode_next = etl_pkg::M_IDLE;
        end
      end
    endcase
  end

  // outputs of the state machine: emission, token bookkeeping, replay list
  always_comb begin
    take         = 1'b1;
    em_v         = 1'b0;
    em           = '{kind: etl_pkg::K_STOP, start: f.pos, len: '0, first: '0};
    ts_next      = ts;
    tl_next      = tl;
    tf_next      = tf;
    pc_next      = pc;
    pend_next[0] = pend[0];
    pend_next[1] = pend[1];
    drop_n       = 2'd0;
    d0           = '{ch: pend[0], pos: etl_pkg::sat_pos(sum_end0, POS_TOP)};
    d1           = '{ch: pend[1], pos: etl_pkg::sat_pos(sum_end1, POS_TOP)};
    case (mode)
      etl_pkg::M_SYM: begin
        if (f.ch.cls.digit || f.ch.cls.alpha) begin
          tl_next = etl_pkg::sat_pos(sum_tl1, POS_TOP);
        end else begin
          take    = 1'b0;
          em_v    = 1'b1;
          em      = '{kind: etl_pkg::K_SYM, start: ts, len: tl, first: tf};
          tl_next = '0;
          pc_next = 2'd0;
        end
      end
      etl_pkg::M_INT, etl_pkg::M_FRAC, etl_pkg::M_EDIG: begin
        if (f.ch.cls.digit || (mode == etl_pkg::M_INT && f.ch.cls.dot)) begin
          tl_next = etl_pkg::sat_pos(sum_tl1, POS_TOP);
        end else if (mode != etl_pkg::M_EDIG && f.ch.cls.expo) begin
          pc_next      = 2'd1;
          pend_next[0] = f.ch;
        end else begin
          take    = 1'b0;
          em_v    = 1'b1;
          em      = '{kind: etl_pkg::K_NUM, start: ts, len: tl, first: tf};
          tl_next = '0;
          pc_next = 2'd0;
        end
      end
      etl_pkg::M_EXP, etl_pkg::M_ESIGN: begin
        if (f.ch.cls.digit) begin
          tl_next = etl_pkg::sat_pos(sum_tlpc, POS_TOP);
          pc_next = 2'd0;
        end else if (mode == etl_pkg::M_EXP && (f.ch.cls.plus || f.ch.cls.minus)) begin
          pend_next[1] = f.ch;
          pc_next      = 2'd2;
        end else begin
          // the exponent marker and any sign go back for another pass
          take    = 1'b0;
          em_v    = 1'b1;
          em      = '{kind: etl_pkg::K_NUM, start: ts, len: tl, first: tf};
          drop_n  = pc;
          tl_next = '0;
          pc_next = 2'd0;
        end
      end
      etl_pkg::M_MINUS, etl_pkg::M_DOT: begin
        if (f.ch.cls.digit) begin
          tl_next = etl_pkg::pos_t'(pc) + etl_pkg::pos_t'(1);
          pc_next = 2'd0;
        end else if (mode == etl_pkg::M_MINUS && f.ch.cls.dot) begin
          pend_next[1] = f.ch;
          pc_next      = 2'd2;
        end else begin
          // lone minus or dot becomes an operator, a held dot is lexed again
          take    = 1'b0;
          em_v    = 1'b1;
          em      = '{kind: etl_pkg::K_OP, start: ts, len: etl_pkg::pos_t'(1),
                      first: pend[0].code};
          drop_n  = (pc == 2'd2) ? 2'd1 : 2'd0;
          d0      = '{ch: pend[1], pos: etl_pkg::sat_pos(sum_end1, POS_TOP)};
          tl_next = '0;
          pc_next = 2'd0;
        end
      end
      default: begin
        if (f.ch.cls.nul) begin
          em_v = 1'b1;
          em   = '{kind: etl_pkg::K_STOP, start: f.pos, len: '0, first: '0};
        end else if (f.ch.cls.space) begin
          em_v = 1'b0;
        end else if (f.ch.cls.rparen) begin
          em_v = 1'b1;
          em   = '{kind: etl_pkg::K_RP, start: f.pos, len: etl_pkg::pos_t'(1),
                   first: f.ch.code};
        end else if (f.ch.cls.lparen) begin
          em_v = 1'b1;
          em   = '{kind: etl_pkg::K_LP, start: f.pos, len: etl_pkg::pos_t'(1),
                   first: f.ch.code};
        end else if (f.ch.cls.equal) begin
          em_v = 1'b1;
          em   = '{kind: etl_pkg::K_EQ, start: f.pos, len: etl_pkg::pos_t'(1),
                   first: f.ch.code};
        end else if (f.ch.cls.digit || f.ch.cls.alpha) begin
          ts_next = f.pos;
          tf_next = f.ch.code;
          tl_next = etl_pkg::pos_t'(1);
          pc_next = 2'd0;
        end else if (f.ch.cls.dot || (f.ch.cls.minus && sign_ok)) begin
          ts_next      = f.pos;
          tf_next      = f.ch.code;
          tl_next      = '0;
          pc_next      = 2'd1;
          pend_next[0] = f.ch;
        end else begin
          em_v = 1'b1;
          em   = '{kind: etl_pkg::K_OP, start: f.pos, len: etl_pkg::pos_t'(1),
                   first: f.ch.code};
        end
      end
    endcase

    lc_next = (em_v && em.kind != etl_pkg::K_STOP) ? em.kind : lc;

    // end of text: back to the start-of-text state
    if (take && f.ch.cls.nul) begin
      lc_next = etl_pkg::K_LP;
      ts_next = '0;
      tl_next = '0;
      tf_next = '0;
      pc_next = 2'd0;
    end
  end

  assign o_free = !o_v || m_ready;
  assign go     = f_v && (!em_v || !h_v || o_free);
  assign h_move = h_v && o_free && (h_fin || (go && em_v));
  assign q_pop  = go && take && (r_cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= etl_pkg::M_IDLE;
      lc   <= etl_pkg::K_LP;
      ts   <= '0;
      tl   <= '0;
      tf   <= '0;
      pc   <= 2'd0;
    end else if (go) begin
      mode <= mode_next;
      lc   <= lc_next;
      ts   <= ts_next;
      tl   <= tl_next;
      tf   <= tf_next;
      pc   <= pc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pend[0] <= pend_next[0];
      pend[1] <= pend_next[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt <= 2'd0;
    end else if (go) begin
      if (!take && drop_n != 2'd0) begin
        r_cnt <= drop_n;
      end else if (take && r_cnt != 2'd0) begin
        r_cnt <= r_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      if (!take && drop_n != 2'd0) begin
        rb[0] <= d0;
        rb[1] <= d1;
      end else if (take && r_cnt != 2'd0) begin
        rb[0] <= rb[1];
      end
    end
  end

  // a result waits in staging until the next one shows up or its byte is done
  always_ff @(posedge clk) begin
    if (rst) begin
      h_v   <= 1'b0;
      h_fin <= 1'b0;
      o_v   <= 1'b0;
    end else begin
      if (go && em_v) begin
        h_v   <= 1'b1;
        h_fin <= q_pop;
      end else if (h_move) begin
        h_v <= 1'b0;
      end else if (q_pop && h_v) begin
        h_fin <= 1'b1;
      end
      if (h_move) begin
        o_v <= 1'b1;
      end else if (m_ready) begin
        o_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && em_v) begin
      h_tok <= em;
    end
    if (h_move) begin
      o_tok  <= h_tok;
      o_last <= h_fin;
    end
  end

  assign m_valid = o_v;
  assign m_token = o_tok;
  assign m_last  = o_last;

endmodule

/* rtl/expression_token_lexer_unit.sv */
// top level of the expression token lexer
// Takes expression text one byte per request on the s_ side, skips whitespace and
// returns token spans on the m_ side: kind in m_tuser, start offset, length and
// first byte in m_tdata, with m_tlast on the last token caused by an input byte.
// A zero byte flushes any open token, returns a stop token and restarts offsets at 0.
// Throughput is one byte per cycle while no token is held back on the m_ side; a byte
// takes another engine step for each token it closes and for each held byte ("." after
// "-", "e", "e+") that is lexed again. The lexer engine does one state machine step per
// cycle while it has a byte and room for its result, and a four-entry queue lets the
// byte intake run ahead of it.
module expression_token_lexer_unit #(
  parameter int MAX_TEXT = etl_pkg::MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // start_pos[11:0], token_len[23:12], first_char[31:24]
  output logic [2:0]  m_tuser,   // token_kind
  output logic        m_tlast
);

  logic            f_valid;
  logic            f_ready;
  etl_pkg::item_t  f_item;
  logic            q_valid;
  logic            q_pop;
  etl_pkg::item_t  q_item;
  etl_pkg::token_t tok;

  etl_front #(
    .MAX_TEXT (MAX_TEXT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  etl_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  etl_back #(
    .MAX_TEXT (MAX_TEXT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_token (tok),
    .m_last  (m_tlast)
  );

  assign m_tdata = {tok.first, tok.len, tok.start};
  assign m_tuser = tok.kind;

  // engine only consumes bytes that are in the queue
  a_pop_valid : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("lexer engine popped an empty queue");

  // intake only backs up when the queue actually holds bytes
  a_full_nonempty : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("intake stalled with an empty queue");

  // a stop token always closes its run
  a_stop_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == etl_pkg::K_STOP) |-> m_tlast)
    else $error("stop token without tlast");

  // only stop tokens have zero length
  a_len_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == etl_pkg::K_STOP) == (m_tdata[23:12] == 12'd0)))
    else $error("token length does not match token kind");

endmodule
